// ===== sv/dcse_pkg.sv =====
// ----------------------------------------------------------------------------
// dcse_pkg
// Types, constants and helper functions for the disjoint cover set evaluator.
// ----------------------------------------------------------------------------
package dcse_pkg;

  localparam int MAX_TARGETS = 64;
  localparam int LIFE_W      = 16;
  localparam int PRICE_W     = 16;
  localparam int SUM_W       = 24;
  localparam int COUNT_W     = 9;
  localparam int TCOUNT_W    = 7;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LIFE_W-1:0]  LIFE_INIT = {LIFE_W{1'b1}};

  typedef logic [MAX_TARGETS-1:0] mask_t;

  // One sensor transaction
  typedef struct packed {
    logic [LIFE_W-1:0]  lifetime;
    logic [PRICE_W-1:0] price;
    mask_t              coverage_mask;
    logic               last_sensor;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic               set_closed;
    logic [COUNT_W-1:0] cover_set_count;
    logic [SUM_W-1:0]   total_lifetime;
    logic [SUM_W-1:0]   total_price;
    logic               done_res;
  } out_item_t;

  // Mask of targets 0..n-1, with n clamped to MAX_TARGETS
  function automatic mask_t need_mask_f(input logic [TCOUNT_W-1:0] tcount);
    logic [TCOUNT_W-1:0] n;
    mask_t               m;
    n = (tcount > TCOUNT_W'(MAX_TARGETS)) ? TCOUNT_W'(MAX_TARGETS) : tcount;
    for (int j = 0; j < MAX_TARGETS; j++) begin
      m[j] = (TCOUNT_W'(j) < n);
    end
    return m;
  endfunction

  // 24-bit add that sticks at all ones
  function automatic logic [SUM_W-1:0] sat_add_f(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/dcse_in_stage.sv =====
// ----------------------------------------------------------------------------
// dcse_in_stage
// Input register: captures one sensor transaction and holds it until the
// evaluation stage takes it.
// ----------------------------------------------------------------------------
module dcse_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dcse_pkg::in_item_t in_data,
  input  logic               take,      // evaluation stage consumes the held item
  output logic               hold_valid,
  output dcse_pkg::in_item_t hold_data
);
  import dcse_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t data_r;
  logic     load;

  // Stall only while holding an item that is not being taken
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;

endmodule

// ===== sv/dcse_accum.sv =====
// ----------------------------------------------------------------------------
// dcse_accum
// Cover set accumulator: open set state, running totals and the result of
// the sensor being evaluated.
// ----------------------------------------------------------------------------
module dcse_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                fire,     // evaluate item and commit state
  input  dcse_pkg::in_item_t  item,
  output dcse_pkg::out_item_t result
);
  import dcse_pkg::*;

  // Configured target mask
  mask_t need_r;

  // Open set
  mask_t              cov_r,   cov_nxt;
  logic [LIFE_W-1:0]  min_r,   min_nxt;
  logic [SUM_W-1:0]   psum_r,  psum_nxt;
  // Totals
  logic [COUNT_W-1:0] cnt_r,   cnt_nxt;
  logic [SUM_W-1:0]   tlife_r, tlife_nxt;
  logic [SUM_W-1:0]   tprice_r, tprice_nxt;

  logic               live, closed;
  mask_t              cov_upd;
  logic [LIFE_W-1:0]  min_upd;
  logic [SUM_W-1:0]   psum_upd;
  logic [COUNT_W-1:0] cnt_upd;
  logic [SUM_W-1:0]   tlife_upd, tprice_upd;

  // Target mask register, kept from the last write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= need_mask_f(TCOUNT_W'(MAX_TARGETS));
    end else if (cfg_we) begin
      need_r <= need_mask_f(cfg_wdata);
    end
  end

  // Candidate updates for a live sensor
  always_comb begin
    live       = (item.lifetime != '0);
    cov_upd    = cov_r | (item.coverage_mask & need_r);
    min_upd    = (item.lifetime < min_r) ? item.lifetime : min_r;
    psum_upd   = sat_add_f(psum_r, SUM_W'(item.price));
    closed     = live && (cov_upd == need_r);
    cnt_upd    = (cnt_r < COUNT_MAX) ? cnt_r + COUNT_W'(1) : cnt_r;
    tlife_upd  = sat_add_f(tlife_r, SUM_W'(min_upd));
    tprice_upd = sat_add_f(tprice_r, psum_upd);
  end

  // Result, reporting totals including a set closed here
  always_comb begin
    result.set_closed      = closed;
    result.cover_set_count = closed ? cnt_upd    : cnt_r;
    result.total_lifetime  = closed ? tlife_upd  : tlife_r;
    result.total_price     = closed ? tprice_upd : tprice_r;
    result.done_res        = item.last_sensor;
  end

  // Next state
  always_comb begin
    cov_nxt    = cov_r;
    min_nxt    = min_r;
    psum_nxt   = psum_r;
    cnt_nxt    = cnt_r;
    tlife_nxt  = tlife_r;
    tprice_nxt = tprice_r;
    priority if (item.last_sensor) begin
      cov_nxt    = '0;
      min_nxt    = LIFE_INIT;
      psum_nxt   = '0;
      cnt_nxt    = '0;
      tlife_nxt  = '0;
      tprice_nxt = '0;
    end else if (closed) begin
      cov_nxt    = '0;
      min_nxt    = LIFE_INIT;
      psum_nxt   = '0;
      cnt_nxt    = cnt_upd;
      tlife_nxt  = tlife_upd;
      tprice_nxt = tprice_upd;
    end else if (live) begin
      cov_nxt    = cov_upd;
      min_nxt    = min_upd;
      psum_nxt   = psum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_r    <= '0;
      min_r    <= LIFE_INIT;
      psum_r   <= '0;
      cnt_r    <= '0;
      tlife_r  <= '0;
      tprice_r <= '0;
    end else if (fire) begin
      cov_r    <= cov_nxt;
      min_r    <= min_nxt;
      psum_r   <= psum_nxt;
      cnt_r    <= cnt_nxt;
      tlife_r  <= tlife_nxt;
      tprice_r <= tprice_nxt;
    end
  end

endmodule

// ===== sv/disjoint_cover_set_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// disjoint_cover_set_evaluator_top
// Scores one sensor ordering by greedily forming disjoint target cover sets.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------
//   in_     | input     | in_valid/in_stall  | in_data  (in_item_t)
//   out_    | output    | out_valid/out_stall| out_data (out_item_t)
//   cfg_    | input     | cfg_we             | cfg_wdata (target count)
//
// One transaction per cycle sustained while out_stall is low; a sensor is
// accepted into the input register, then evaluated into the result register,
// from which its result is taken. The set update is combinational between
// the two registers.
// Reset (rst_n low, synchronous) clears the set, the totals and sets the
// target count to 64. out_stall holds the result register, which stalls the
// input register; in_stall rises only while the input register is full.
// ----------------------------------------------------------------------------
module disjoint_cover_set_evaluator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dcse_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dcse_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);
  import dcse_pkg::*;

  logic      hold_valid;
  in_item_t  hold_data;
  logic      adv;
  logic      fire;
  out_item_t result;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Result register can load when empty or being drained
  assign adv  = !out_valid_r || !out_stall;
  assign fire = hold_valid && adv;

  dcse_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  dcse_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (hold_data),
    .result    (result)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Assertions
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> hold_valid)
    else $error("input stalled with an empty input register");

  a_closed_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.set_closed) |-> (out_data.cover_set_count != '0))
    else $error("closed set reported with zero count");

  a_zero_count_zero_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.cover_set_count == '0) |->
      (out_data.total_lifetime == '0 && out_data.total_price == '0))
    else $error("totals nonzero with no closed set");

  a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("evaluated transaction did not reach the result register");

endmodule
